// ----- rtl/egcd_pkg.sv -----
package egcd_pkg;

   localparam int WIDTH   = 31;
   localparam int COEF_W  = WIDTH + 1;
   localparam int SHIFT_W = $clog2(WIDTH);
   localparam int AMT_W   = SHIFT_W + 1;

   // sequencer to datapath
   typedef struct packed {
      logic load;
      logic grow;
      logic reduce;
   } ctrl_type;

   // datapath to sequencer
   typedef struct packed {
      logic fits;
      logic k_zero;
      logic rem_zero;
   } status_type;

endpackage

// ----- rtl/egcd_req_if.sv -----
interface egcd_req_if;
   import egcd_pkg::*;

   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] value_a;
   logic [WIDTH-1:0] value_b;

   modport source (output valid, output value_a, output value_b, input ready);
   modport sink   (input valid, input value_a, input value_b, output ready);

endinterface

// ----- rtl/egcd_rsp_if.sv -----
interface egcd_rsp_if;
   import egcd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [WIDTH-1:0]         divisor;
   logic signed [COEF_W-1:0] coef_a;
   logic signed [COEF_W-1:0] coef_b;

   modport source (output valid, output divisor, output coef_a, output coef_b, input ready);
   modport sink   (input valid, input divisor, input coef_a, input coef_b, output ready);

endinterface

// ----- rtl/egcd_datapath.sv -----
module egcd_datapath (
   input  logic                            clock,
   input  egcd_pkg::ctrl_type              ctrl,
   input  logic [egcd_pkg::WIDTH-1:0]      value_a,
   input  logic [egcd_pkg::WIDTH-1:0]      value_b,
   output egcd_pkg::status_type            status,
   output logic [egcd_pkg::WIDTH-1:0]      divisor,
   output logic signed [egcd_pkg::COEF_W-1:0] coef_a,
   output logic signed [egcd_pkg::COEF_W-1:0] coef_b
);
   import egcd_pkg::*;

   logic [WIDTH-1:0]   rp_ff, rp_in, rc_ff, rc_in;
   logic [COEF_W-1:0]  sp_ff, sp_in, sc_ff, sc_in;
   logic [COEF_W-1:0]  tp_ff, tp_in, tc_ff, tc_in;
   logic [SHIFT_W-1:0] k_ff, k_in;

   logic [AMT_W-1:0]   amount;
   logic [WIDTH:0]     shifted_r;
   logic [COEF_W-1:0]  shifted_s, shifted_t;
   logic               fits;
   logic [WIDTH-1:0]   rem;
   logic [COEF_W-1:0]  s_new, t_new;

   // shared shift, compare and subtract unit
   // grow probes one position higher, reduce works at the current position
   assign amount    = ctrl.grow ? ({1'b0, k_ff} + AMT_W'(1)) : {1'b0, k_ff};
   assign shifted_r = {1'b0, rc_ff} << amount;
   assign shifted_s = sc_ff << amount;
   assign shifted_t = tc_ff << amount;
   assign fits      = shifted_r <= {1'b0, rp_ff};
   assign rem       = fits ? (rp_ff - shifted_r[WIDTH-1:0]) : rp_ff;
   assign s_new     = fits ? (sp_ff - shifted_s) : sp_ff;
   assign t_new     = fits ? (tp_ff - shifted_t) : tp_ff;

   always_comb begin
      rp_in = rp_ff;
      rc_in = rc_ff;
      sp_in = sp_ff;
      sc_in = sc_ff;
      tp_in = tp_ff;
      tc_in = tc_ff;
      k_in  = k_ff;
      if (ctrl.load) begin
         rp_in = value_a;
         rc_in = value_b;
         sp_in = COEF_W'(1);
         sc_in = '0;
         tp_in = '0;
         tc_in = COEF_W'(1);
         k_in  = '0;
      end else if (ctrl.grow) begin
         if (fits) begin
            k_in = amount[SHIFT_W-1:0];
         end
      end else if (ctrl.reduce) begin
         if (k_ff == '0) begin
            // quotient complete: rotate the remainder sequence
            rp_in = rc_ff;
            rc_in = rem;
            sp_in = sc_ff;
            sc_in = s_new;
            tp_in = tc_ff;
            tc_in = t_new;
         end else begin
            rp_in = rem;
            sp_in = s_new;
            tp_in = t_new;
            k_in  = k_ff - SHIFT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rp_ff <= rp_in;
      rc_ff <= rc_in;
      sp_ff <= sp_in;
      sc_ff <= sc_in;
      tp_ff <= tp_in;
      tc_ff <= tc_in;
      k_ff  <= k_in;
   end

   assign status.fits     = fits;
   assign status.k_zero   = (k_ff == '0);
   assign status.rem_zero = (rem == '0);

   assign divisor = rp_ff;
   assign coef_a  = sp_ff;
   assign coef_b  = tp_ff;

endmodule

// ----- rtl/egcd_sequencer.sv -----
module egcd_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 b_zero,
   input  logic                 rsp_ready,
   input  egcd_pkg::status_type status,
   output egcd_pkg::ctrl_type   ctrl,
   output logic                 req_ready,
   output logic                 rsp_valid
);
   import egcd_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_GROW   = 2'd1;
   localparam logic [1:0] ST_REDUCE = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = b_zero ? ST_DONE : ST_GROW;
            end
         end
         ST_GROW: begin
            ctrl.grow = 1'b1;
            // stop widening once the next shift would overshoot
            if (!status.fits) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            ctrl.reduce = 1'b1;
            if (status.k_zero) begin
               state_in = status.rem_zero ? ST_DONE : ST_GROW;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

`ifndef ASSERT_OFF
   a_ctrl_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.load, ctrl.grow, ctrl.reduce}))
      else $error("more than one datapath command at once");

   a_zero_b_direct: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && b_zero) |=> rsp_valid)
      else $error("request with zero second operand not answered at once");

   a_descend_stays: assert property (@(posedge clock) disable iff (reset)
      (ctrl.reduce && !status.k_zero) |=> ctrl.reduce)
      else $error("quotient bit loop left before reaching position zero");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result is pending");
`endif

endmodule

// ----- rtl/extended_gcd_bezout_unit.sv -----
// Each request is loaded, then for every quotient the shift is widened (grow) and the
// quotient is built one bit position at a time back down to zero (reduce).
// One request at a time: a new request is taken only in idle, once the result has gone.
// All steps share one shift/compare/subtract unit.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// any request in flight; no state survives between requests.
module extended_gcd_bezout_unit (
   input logic       clock,
   input logic       reset,
   egcd_req_if.sink   req_if,
   egcd_rsp_if.source rsp_if
);
   import egcd_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   egcd_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .b_zero    (req_if.value_b == '0),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .ctrl      (ctrl),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid)
   );

   egcd_datapath u_datapath (
      .clock   (clock),
      .ctrl    (ctrl),
      .value_a (req_if.value_a),
      .value_b (req_if.value_b),
      .status  (status),
      .divisor (rsp_if.divisor),
      .coef_a  (rsp_if.coef_a),
      .coef_b  (rsp_if.coef_b)
   );

endmodule
